// ===== hw/rtl/spm_pkg.sv =====
// Shared types, constants and the log2 table of the stereo peak meter.
`timescale 1ns / 1ps

package spm_pkg;

   // Number of intervals in the log2 interpolation table.
   localparam int LOG_TABLE_ENTRIES = 64;
   localparam int NUM_LANES         = 2;
   localparam int SAMPLE_W          = 16;
   localparam int TAB_W             = $clog2(LOG_TABLE_ENTRIES + 1);
   localparam int IDX_PROD_W        = 15 + TAB_W;
   localparam int LQ_W              = 21;
   localparam int DB_PROD_W         = 41;
   localparam int CSR_ADDR_W        = 2;

   // 20*log10(2) in Q16.
   localparam logic signed [DB_PROD_W-1:0] DB_PER_LOG2_Q16 = 41'sd394566;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_COEFF     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOOR_THRESHOLD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOOR_DB        = 2'd2;

   localparam logic [15:0]        DECAY_COEFF_RESET     = 16'd5243;
   localparam logic [15:0]        FLOOR_THRESHOLD_RESET = 16'd33;
   localparam logic signed [15:0] FLOOR_DB_RESET        = -16'sd15360;

   typedef struct packed {
      logic [15:0]        decay_coeff;
      logic [15:0]        floor_threshold;
      logic signed [15:0] floor_db;
   } spm_cfg_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic signed [15:0]  level_db;
   } spm_lane_out_type;

   typedef logic [16:0] log_table_type [0:LOG_TABLE_ENTRIES];

   // log2(1 + i/N) in Q16, truncated, built by repeated squaring of a Q30 mantissa.
   function automatic log_table_type build_log_table();
      log_table_type tab;
      logic [63:0]   x;
      logic [16:0]   r;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
         r = 17'd0;
         for (int b = 15; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               x    = x >> 1;
               r[b] = 1'b1;
            end
         end
         tab[i] = r;
      end
      tab[LOG_TABLE_ENTRIES] = 17'd65536;
      return tab;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

// ===== hw/rtl/spm_lane.sv =====
// One channel lane: release ballistics, log2 by table interpolation and dB scaling.
`timescale 1ns / 1ps

module spm_lane
   import spm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] peak,
   input  logic [15:0]         decay_coeff,
   output spm_lane_out_type    lane_out,
   output logic                done
);

   logic [6:0] stage_v_ff, stage_v_in;

   // Stage A: attack decision and release step.
   logic                attack_ff, attack_in;
   logic [SAMPLE_W-1:0] peak_ff;
   logic [15:0]         dec_ff;
   logic [31:0]         dec_prod;

   // Stage B: kept smoothed level.
   logic [SAMPLE_W-1:0] level_ff, level_in;

   // Stage C: normalisation and table index.
   logic [3:0]            exp_ff, exp_in;
   logic [TAB_W-1:0]      idx_ff;
   logic [14:0]           rem_ff;
   logic [15:0]           mant;
   logic [IDX_PROD_W-1:0] idx_prod;

   // Stage D: interpolation product.
   logic [16:0] t0_ff, t_diff;
   logic [3:0]  exp_d_ff;
   logic [31:0] ip_ff, ip_in;

   // Stage E: log2 in Q16.
   logic signed [LQ_W-1:0] lq_ff, lq_in;
   logic signed [4:0]      exp_s;
   logic [16:0]            frac;

   // Stage F and G: dB scaling and rounding.
   logic signed [DB_PROD_W-1:0] v_ff, v_in;
   logic [DB_PROD_W-1:0]        v_mag, v_rnd;
   logic signed [15:0]          db_ff, db_in;

   assign stage_v_in = {stage_v_ff[5:0], start};

   assign attack_in = peak > level_ff;
   assign dec_prod  = 32'(level_ff - peak) * 32'(decay_coeff);
   assign level_in  = attack_ff ? peak_ff : level_ff - dec_ff;

   always_comb begin
      exp_in = 4'd0;
      for (int b = 0; b < SAMPLE_W; b++) begin
         if (level_ff[b]) begin
            exp_in = 4'(b);
         end
      end
   end

   assign mant     = 16'(level_ff << (4'd15 - exp_in));
   assign idx_prod = IDX_PROD_W'(mant[14:0]) * IDX_PROD_W'(LOG_TABLE_ENTRIES);

   assign t_diff = LOG_TABLE[idx_ff + 1'b1] - LOG_TABLE[idx_ff];
   assign ip_in  = 32'(t_diff) * 32'(rem_ff);

   assign frac  = t0_ff + 17'(ip_ff >> 15);
   assign exp_s = $signed({1'b0, exp_d_ff}) - 5'sd15;
   assign lq_in = $signed({exp_s, 16'd0}) + $signed({4'd0, frac});

   assign v_in = DB_PROD_W'(lq_ff) * DB_PER_LOG2_Q16;

   // Round to nearest with halves away from zero.
   assign v_mag = v_ff[DB_PROD_W-1] ? DB_PROD_W'(-v_ff) : DB_PROD_W'(v_ff);
   assign v_rnd = v_mag + (DB_PROD_W'(1) << 23);
   assign db_in = v_ff[DB_PROD_W-1] ? $signed(16'(-v_rnd[39:24])) : $signed(v_rnd[39:24]);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
         level_ff   <= '0;
      end else begin
         stage_v_ff <= stage_v_in;
         if (stage_v_ff[0]) begin
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         attack_ff <= attack_in;
         peak_ff   <= peak;
         dec_ff    <= dec_prod[31:16];
      end
      if (stage_v_ff[1]) begin
         exp_ff <= exp_in;
         idx_ff <= TAB_W'(idx_prod >> 15);
         rem_ff <= idx_prod[14:0];
      end
      if (stage_v_ff[2]) begin
         t0_ff    <= LOG_TABLE[idx_ff];
         exp_d_ff <= exp_ff;
         ip_ff    <= ip_in;
      end
      if (stage_v_ff[3]) begin
         lq_ff <= lq_in;
      end
      if (stage_v_ff[4]) begin
         v_ff <= v_in;
      end
      if (stage_v_ff[5]) begin
         db_ff <= db_in;
      end
   end

   assign lane_out.level    = level_ff;
   assign lane_out.level_db = db_ff;
   assign done              = stage_v_ff[6];

endmodule

// ===== hw/rtl/spm_merge.sv =====
// Merging stage: floor selection for both lanes and the result output register.
`timescale 1ns / 1ps

module spm_merge
   import spm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  spm_cfg_type      cfg,
   input  spm_lane_out_type lane_out [NUM_LANES],
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata
);

   logic        valid_ff, valid_in;
   logic [63:0] data_ff, data_in;
   logic [15:0] db_sel [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         db_sel[l] = (lane_out[l].level > cfg.floor_threshold) ?
                     lane_out[l].level_db : cfg.floor_db;
      end
   end

   assign data_in  = {lane_out[1].level, lane_out[0].level, db_sel[1], db_sel[0]};
   assign valid_in = load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== hw/rtl/stereo_peak_meter_ballistics.sv =====
// Top level of the stereo peak meter with instant attack and exponential release.
`timescale 1ns / 1ps

// Usage
// The req_ channel takes one transaction per meter update: the fresh left and right
// linear peaks in unsigned Q1.15. The rsp_ channel returns one transaction per
// update: both smoothed levels in dB (signed Q7.8, replaced by the floor value at
// or below the threshold) and both smoothed linear levels after the update.
// The csr_ port writes decay_coeff (index 0), floor_threshold (1) and floor_db (2);
// write only while no transaction is in flight. A result appears on rsp_tvalid after
// the seven register stages of each channel lane (release multiply, level update,
// normalisation, interpolation multiply, log2 sum, dB multiply, rounding) and the
// load of the output register. A new transaction is taken only after the last one
// has been loaded into the output register. The two channels run in parallel lanes
// that are started together and run the same step sequence.
// Reset clears both smoothed levels to zero and restores the register defaults.
// A stalled receiver holds its result in the output register while the next request
// is taken and worked on; that request then waits in its lanes until the output
// register frees, and req_tready stays low meanwhile.

module stereo_peak_meter_ballistics
   import spm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // left_peak, right_peak
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // left_level_db, right_level_db,
                                              // left_smoothed, right_smoothed
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   spm_cfg_type      cfg_ff, cfg_in;
   spm_lane_out_type lane_out [NUM_LANES];
   logic [NUM_LANES-1:0] lane_done;
   logic             req_accept;
   logic             out_free;
   logic             load;

   // Configuration registers; an unused index is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DECAY_COEFF:     cfg_in.decay_coeff     = csr_wdata;
            CSR_FLOOR_THRESHOLD: cfg_in.floor_threshold = csr_wdata;
            CSR_FLOOR_DB:        cfg_in.floor_db        = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_coeff     <= DECAY_COEFF_RESET;
         cfg_ff.floor_threshold <= FLOOR_THRESHOLD_RESET;
         cfg_ff.floor_db        <= FLOOR_DB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid | rsp_tready;

   // The lanes hold their final results, so a finished transaction can wait in HOLD.
   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (lane_done[0]) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      spm_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .start       (req_accept),
         .peak        (req_tdata[l*SAMPLE_W +: SAMPLE_W]),
         .decay_coeff (cfg_ff.decay_coeff),
         .lane_out    (lane_out[l]),
         .done        (lane_done[l])
      );
   end

   spm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .cfg        (cfg_ff),
      .lane_out   (lane_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // Both lanes run the same step sequence and must finish together.
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] == lane_done[1])
      else $error("channel lanes finished in different cycles");

   // A lane result may only arrive while a transaction is being worked on.
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> state_ff == ST_BUSY)
      else $error("lane finished outside the busy state");

   // An accepted request starts work in the next cycle.
   a_accept_to_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_BUSY)
      else $error("accepted request did not start work");

   // A finished transaction waits only behind a result that is still held.
   a_hold_needs_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_tvalid)
      else $error("hold state without a pending result");
`endif

endmodule
